@@ hw/rtl/motion_gated_deviation_averager_unit_macros.svh @@
// Assertion helpers used by the top-level file of this block.
// Both sample on clk and stay off while rst_n is low.
`ifndef MOTION_GATED_DEVIATION_AVERAGER_UNIT_MACROS_SVH
`define MOTION_GATED_DEVIATION_AVERAGER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MGDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MGDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mgda_pkg.sv @@
`default_nettype none
package mgda_pkg;

  localparam int unsigned MAX_SAMPLES = 8191;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AVG_W   = 14;
  localparam int unsigned SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned DVD_W   = SUM_W + FRAC_W;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(40);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_SAMPLES);
  localparam logic [AVG_W-1:0] AVG_MAX   = {AVG_W{1'b1}};

  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BTN1   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BTN2   = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 3'd0,
    MODE_ACQ    = 3'd1,
    MODE_FULL   = 3'd2,
    MODE_PAUSE  = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_RESULT = 3'd5
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic step;      // apply the accepted item
    logic div_step;  // one quotient bit
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_req;   // accepted item starts a division
    logic div_last;  // final quotient bit this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/mgda_ifs.sv @@
`default_nettype none
interface mgda_in_if;
  import mgda_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       action;
  logic [SAMPLE_BITS-1:0] accel_x;
  logic [SAMPLE_BITS-1:0] accel_y;
  logic [SAMPLE_BITS-1:0] accel_z;
  modport source (output valid, action, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, action, accel_x, accel_y, accel_z, output ready);
endinterface

interface mgda_out_if;
  import mgda_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              recorded;
  logic              buzzer_on;
  logic [CNT_W-1:0]  sample_total;
  logic [AVG_W-1:0]  average_q4;
  logic              average_valid;
  modport source (output valid, mode, recorded, buzzer_on, sample_total, average_q4,
                  average_valid, input ready);
  modport sink   (input valid, mode, recorded, buzzer_on, sample_total, average_q4,
                  average_valid, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mgda_ctrl.sv @@
`default_nettype none
module mgda_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mgda_pkg::dp_stat_t stat,
  output mgda_pkg::dp_cmd_t       cmd
);
  import mgda_pkg::*;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_DIV,
    ST_RESP
  } ctrl_state_t;

  ctrl_state_t state_r;
  logic        in_ready_r;
  logic        out_valid_r;
  logic        accept;

  assign accept       = in_valid && in_ready_r;
  assign cmd.step     = accept;
  assign cmd.div_step = (state_r == ST_DIV);
  assign in_ready     = in_ready_r;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_WAIT: begin
          if (accept) begin
            in_ready_r <= 1'b0;
            if (stat.div_req) begin
              state_r <= ST_DIV;
            end else begin
              state_r     <= ST_RESP;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (stat.div_last) begin
            state_r     <= ST_RESP;
            out_valid_r <= 1'b1;
          end
        end
        ST_RESP: begin
          if (out_ready) begin
            state_r     <= ST_WAIT;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_WAIT;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/mgda_datapath.sv @@
`default_nettype none
module mgda_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [mgda_pkg::THR_W-1:0]         cfg_wr_data,
  input  wire logic [mgda_pkg::ACT_W-1:0]         action,
  input  wire logic [mgda_pkg::SAMPLE_BITS-1:0]   accel_x,
  input  wire logic [mgda_pkg::SAMPLE_BITS-1:0]   accel_y,
  input  wire logic [mgda_pkg::SAMPLE_BITS-1:0]   accel_z,
  input  wire mgda_pkg::dp_cmd_t                  cmd,
  output mgda_pkg::dp_stat_t                      stat,
  output logic [mgda_pkg::MODE_W-1:0]             mode,
  output logic                                    recorded,
  output logic                                    buzzer_on,
  output logic [mgda_pkg::CNT_W-1:0]              sample_total,
  output logic [mgda_pkg::AVG_W-1:0]              average_q4,
  output logic                                    average_valid
);
  import mgda_pkg::*;

  logic [THR_W-1:0]       thr_r;
  mode_t                  mode_r, mode_nxt;
  logic [SAMPLE_BITS-1:0] ref_x_r, ref_x_nxt;
  logic [SAMPLE_BITS-1:0] ref_y_r, ref_y_nxt;
  logic [SAMPLE_BITS-1:0] ref_z_r, ref_z_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [AVG_W-1:0]       avg_r, avg_nxt;
  logic                   rec_r, rec_nxt;

  // restoring divider: dvd_r shifts the dividend out and the quotient in
  logic [DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic [CNT_W:0]         trial;
  logic                   fits;

  logic [SAMPLE_BITS-1:0] dx, dy, dz;
  logic                   moved;
  logic [CNT_W-1:0]       cnt_inc;

  assign dx = (accel_x > ref_x_r) ? accel_x - ref_x_r : ref_x_r - accel_x;
  assign dy = (accel_y > ref_y_r) ? accel_y - ref_y_r : ref_y_r - accel_y;
  assign dz = (accel_z > ref_z_r) ? accel_z - ref_z_r : ref_z_r - accel_z;
  assign moved   = (dx > thr_r) || (dy > thr_r);
  assign cnt_inc = cnt_r + CNT_W'(1);

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, cnt_r});

  assign stat.div_req  = (mode_r == MODE_STOP) && (action == ACT_BTN2) && (cnt_r != '0);
  assign stat.div_last = (dcnt_r == '0);

  always_comb begin
    mode_nxt  = mode_r;
    ref_x_nxt = ref_x_r;
    ref_y_nxt = ref_y_r;
    ref_z_nxt = ref_z_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    avg_nxt   = avg_r;
    rec_nxt   = rec_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;

    if (cmd.step) begin
      rec_nxt = 1'b0;
      unique case (mode_r)
        MODE_ACQ: begin
          if (action == ACT_SAMPLE) begin
            if (moved && (cnt_r < CNT_LIMIT)) begin
              sum_nxt = sum_r + SUM_W'(dz);
              cnt_nxt = cnt_inc;
              rec_nxt = 1'b1;
            end
            if (cnt_nxt >= CNT_LIMIT) begin
              mode_nxt = MODE_FULL;
            end
          end else if (action == ACT_BTN1) begin
            mode_nxt = MODE_PAUSE;
          end else if (action == ACT_BTN2) begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_FULL: begin
          if (action == ACT_BTN1) mode_nxt = MODE_STOP;
        end
        MODE_PAUSE: begin
          if (action == ACT_BTN1) mode_nxt = MODE_ACQ;
        end
        MODE_STOP: begin
          if (action == ACT_BTN1) begin
            cnt_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end else if (action == ACT_BTN2) begin
            mode_nxt = MODE_RESULT;
            avg_nxt  = '0;
            dvd_nxt  = {sum_r, {FRAC_W{1'b0}}};
            rem_nxt  = '0;
            dcnt_nxt = DCNT_W'(DVD_W - 1);
          end
        end
        MODE_RESULT: begin
          if (action == ACT_BTN1) begin
            cnt_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          if (action == ACT_BTN1) begin
            ref_x_nxt = accel_x;
            ref_y_nxt = accel_y;
            ref_z_nxt = accel_z;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            mode_nxt  = MODE_ACQ;
          end
        end
      endcase
    end

    if (cmd.div_step) begin
      rem_nxt  = fits ? CNT_W'(trial - {1'b0, cnt_r}) : trial[CNT_W-1:0];
      dvd_nxt  = {dvd_r[DVD_W-2:0], fits};
      dcnt_nxt = dcnt_r - DCNT_W'(1);
      if (stat.div_last) begin
        avg_nxt = (dvd_nxt > DVD_W'(AVG_MAX)) ? AVG_MAX : dvd_nxt[AVG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      mode_r  <= MODE_IDLE;
      ref_x_r <= '0;
      ref_y_r <= '0;
      ref_z_r <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      avg_r   <= '0;
      rec_r   <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      mode_r  <= mode_nxt;
      ref_x_r <= ref_x_nxt;
      ref_y_r <= ref_y_nxt;
      ref_z_r <= ref_z_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      avg_r   <= avg_nxt;
      rec_r   <= rec_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign mode          = mode_r;
  assign recorded      = rec_r;
  assign buzzer_on     = (mode_r == MODE_FULL);
  assign sample_total  = cnt_r;
  assign average_q4    = (mode_r == MODE_RESULT) ? avg_r : '0;
  assign average_valid = (mode_r == MODE_RESULT) && (cnt_r != '0);

endmodule
`default_nettype wire

@@ hw/rtl/motion_gated_deviation_averager_unit.sv @@
// Motion-gated deviation averager.
// in_if carries one item: a sample (action 0) or a button press (1 or 2),
// with the three accelerometer readings. out_if returns exactly one item per
// input item: the mode after it, whether the sample was recorded, the buzzer,
// the sample count and, in result mode, the Q4 mean |z - z_ref|.
// cfg_wr_en/cfg_wr_data write the horizontal threshold; write only when idle.
// One item is in flight at a time. A result becomes valid in the cycle
// after its item is accepted. Button two in stopped mode with a nonzero count
// instead runs a one-bit-per-cycle restoring divider over the 27-bit scaled
// sum, and that item's result becomes valid once the last quotient bit is in.
// The next item is taken in the cycle after the result is taken.
// While out_if is stalled the result is held and in_if.ready stays low.
// Synchronous reset (rst_n low) returns to idle with all sums, counts and
// references zero and the threshold at 40; no clearing pass is needed.
`default_nettype none
`include "motion_gated_deviation_averager_unit_macros.svh"
module motion_gated_deviation_averager_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mgda_in_if.sink                            in_if,
  mgda_out_if.source                         out_if,
  input  wire logic                          cfg_wr_en,
  input  wire logic [mgda_pkg::THR_W-1:0]    cfg_wr_data
);
  import mgda_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mgda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mgda_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .action        (in_if.action),
    .accel_x       (in_if.accel_x),
    .accel_y       (in_if.accel_y),
    .accel_z       (in_if.accel_z),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (out_if.mode),
    .recorded      (out_if.recorded),
    .buzzer_on     (out_if.buzzer_on),
    .sample_total  (out_if.sample_total),
    .average_q4    (out_if.average_q4),
    .average_valid (out_if.average_valid)
  );

  `MGDA_ASSERT_NOW(a_one_in_flight, in_if.ready, !out_if.valid && !cmd.div_step, "item overlap")
  `MGDA_ASSERT_NEXT(a_accept_progress, in_if.valid && in_if.ready, out_if.valid || cmd.div_step, "accepted item stalled")
  `MGDA_ASSERT_NOW(a_avg_valid_mode, out_if.average_valid, out_if.mode == MODE_RESULT, "average_valid outside result")
  `MGDA_ASSERT_NOW(a_rec_mode, out_if.valid && out_if.recorded, out_if.mode == MODE_ACQ || out_if.mode == MODE_FULL, "recorded outside acquiring")

endmodule
`default_nettype wire

@@ tb/sv/motion_gated_deviation_averager_unit_tb.sv @@
`timescale 1ns / 100ps
module motion_gated_deviation_averager_unit_tb;
  import mgda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned PARK_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RESET_CYCLES = 12;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam logic [THR_W-1:0] THR_TOP = {THR_W{1'b1}};

  typedef logic [SAMPLE_BITS-1:0] reading_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    reading_t x;
    reading_t y;
    reading_t z;
  } motion_item_t;

  typedef struct packed {
    mode_t mode;
    logic recorded;
    logic buzzer_on;
    logic [CNT_W-1:0] sample_total;
    logic [AVG_W-1:0] average_q4;
    logic average_valid;
  } report_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;

  mgda_in_if in_ch ();
  mgda_out_if out_ch ();

  motion_gated_deviation_averager_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mirror of the mode machine
  mode_t m_mode;
  reading_t m_ref_x, m_ref_y, m_ref_z;
  logic [SUM_W-1:0] m_sum;
  logic [CNT_W-1:0] m_count;
  logic [AVG_W-1:0] m_avg;
  logic [THR_W-1:0] m_thr;

  motion_item_t item_backlog[$];
  report_t expected_reports[$];
  motion_item_t tx_item;
  report_t want;

  int unsigned items_queued = 0;
  int unsigned reports_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned stall_left = 0;
  int unsigned park_left = 0;
  logic in_taken = 1'b0;
  logic tx_idling = 1'b1;
  logic rx_idling = 1'b1;
  logic park_req = 1'b0;
  logic park_ack = 1'b0;

  function automatic reading_t spread(reading_t a, reading_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic report_t advance_mode_machine(motion_item_t it);
    report_t r;
    logic moved;
    logic [DVD_W-1:0] quo;
    r = '0;
    moved = (spread(it.x, m_ref_x) > m_thr) || (spread(it.y, m_ref_y) > m_thr);
    case (m_mode)
      MODE_IDLE: begin
        if (it.action == ACT_BTN1) begin
          m_ref_x = it.x;
          m_ref_y = it.y;
          m_ref_z = it.z;
          m_sum = '0;
          m_count = '0;
          m_mode = MODE_ACQ;
        end
      end
      MODE_ACQ: begin
        if (it.action == ACT_SAMPLE) begin
          if (moved && m_count < CNT_LIMIT) begin
            m_sum = m_sum + spread(it.z, m_ref_z);
            m_count = m_count + 1'b1;
            r.recorded = 1'b1;
          end
          if (m_count >= CNT_LIMIT) m_mode = MODE_FULL;
        end else if (it.action == ACT_BTN1) begin
          m_mode = MODE_PAUSE;
        end else if (it.action == ACT_BTN2) begin
          m_mode = MODE_STOP;
        end
      end
      MODE_FULL: if (it.action == ACT_BTN1) m_mode = MODE_STOP;
      MODE_PAUSE: if (it.action == ACT_BTN1) m_mode = MODE_ACQ;
      MODE_STOP: begin
        if (it.action == ACT_BTN1) begin
          m_count = '0;
          m_mode = MODE_IDLE;
        end else if (it.action == ACT_BTN2) begin
          if (m_count == 0) begin
            m_avg = '0;
          end else begin
            quo = {m_sum, {FRAC_W{1'b0}}} / m_count;
            m_avg = (quo > AVG_MAX) ? AVG_MAX : quo[AVG_W-1:0];
          end
          m_mode = MODE_RESULT;
        end
      end
      default: begin
        if (it.action == ACT_BTN1) begin
          m_count = '0;
          m_mode = MODE_IDLE;
        end
      end
    endcase
    r.mode = m_mode;
    r.buzzer_on = (m_mode == MODE_FULL);
    r.sample_total = m_count;
    if (m_mode == MODE_RESULT) begin
      r.average_q4 = m_avg;
      r.average_valid = (m_count != 0);
    end
    return r;
  endfunction

  task automatic compare_field(string field, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      error_count++;
    end
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 48);
    return $urandom_range(1, 3);
  endfunction

  // Sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the item until it is taken
    end else if (tx_gap != 0) begin
      in_ch.valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (item_backlog.size() != 0) begin
      tx_item = item_backlog.pop_front();
      in_ch.action <= tx_item.action;
      in_ch.accel_x <= tx_item.x;
      in_ch.accel_y <= tx_item.y;
      in_ch.accel_z <= tx_item.z;
      in_ch.valid <= 1'b1;
      tx_gap <= (tx_idling && $urandom_range(0, 4) == 0) ? pick_gap() : 0;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (park_left != 0) begin
      out_ch.ready <= 1'b0;
      park_left <= park_left - 1;
    end else if (park_req != park_ack) begin
      out_ch.ready <= 1'b0;
      park_ack <= park_req;
      park_left <= PARK_CYCLES;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_idling && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        reports_checked++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual mode %0d total %0d",
                   $time, out_ch.mode, out_ch.sample_total);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("mode", want.mode, out_ch.mode);
          compare_field("recorded", want.recorded, out_ch.recorded);
          compare_field("buzzer_on", want.buzzer_on, out_ch.buzzer_on);
          compare_field("sample_total", want.sample_total, out_ch.sample_total);
          compare_field("average_q4", want.average_q4, out_ch.average_q4);
          compare_field("average_valid", want.average_valid, out_ch.average_valid);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_reports.push_back(advance_mode_machine(
          {in_ch.action, in_ch.accel_x, in_ch.accel_y, in_ch.accel_z}));
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_item(logic [ACT_W-1:0] a, reading_t x, reading_t y, reading_t z);
    item_backlog.push_back({a, x, y, z});
    items_queued++;
  endtask

  function automatic reading_t any_reading();
    return reading_t'($urandom_range(0, 1023));
  endfunction

  task automatic add_random(logic [ACT_W-1:0] a);
    add_item(a, any_reading(), any_reading(), any_reading());
  endtask

  // Reading at a random distance lo..hi from c, clamped to the converter range
  function automatic reading_t offset_from(reading_t c, int lo, int hi);
    int d, v;
    d = $urandom_range(hi, lo);
    v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return reading_t'(v);
  endfunction

  function automatic reading_t pick_z(reading_t rz);
    if ($urandom_range(0, 3) == 0) return any_reading();
    return offset_from(rz, 0, 64);
  endfunction

  // An action that leaves the mode alone; button two only where it is a no-op
  function automatic logic [ACT_W-1:0] stray_action(bit allow_btn2);
    case ($urandom_range(0, allow_btn2 ? 2 : 1))
      0: return ACT_SAMPLE;
      1: return ACT_NONE;
      default: return ACT_BTN2;
    endcase
  endfunction

  task automatic queue_directed();
    add_item(ACT_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_NONE, 10'd1023, 10'd1023, 10'd1023);
    add_item(ACT_BTN1, 10'd0, 10'd1023, 10'd512);
    add_item(ACT_SAMPLE, 10'd40, 10'd983, 10'd0);    // exactly at threshold
    add_item(ACT_SAMPLE, 10'd41, 10'd1023, 10'd0);
    add_item(ACT_SAMPLE, 10'd0, 10'd982, 10'd1023);
    add_item(ACT_NONE, 10'd1023, 10'd0, 10'd0);
    add_item(ACT_BTN1, 10'd0, 10'd0, 10'd0);
    add_item(ACT_SAMPLE, 10'd1023, 10'd0, 10'd0);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_NONE, 10'd0, 10'd0, 10'd0);
    add_item(ACT_BTN1, 10'd0, 10'd0, 10'd0);
    add_item(ACT_SAMPLE, 10'd1023, 10'd0, 10'd512);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_SAMPLE, 10'd1023, 10'd0, 10'd0);
    add_item(ACT_NONE, 10'd0, 10'd0, 10'd0);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
    add_item(ACT_BTN1, 10'd0, 10'd0, 10'd0);
    // empty session: result with zero count
    add_item(ACT_BTN1, 10'd1023, 10'd0, 10'd0);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_BTN2, 10'd0, 10'd0, 10'd0);
    add_item(ACT_BTN1, 10'd0, 10'd0, 10'd0);
  endtask

  task automatic queue_session(int thr);
    reading_t rx, ry, rz;
    int pick, span;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) add_random(stray_action(1));
    if ($urandom_range(0, 3) == 0) begin
      rx = $urandom_range(0, 1) ? '1 : '0;
      ry = $urandom_range(0, 1) ? '1 : '0;
      rz = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      rx = any_reading();
      ry = any_reading();
      rz = any_reading();
    end
    add_item(ACT_BTN1, rx, ry, rz);
    repeat ($urandom_range(4, 30)) begin
      pick = $urandom_range(0, 99);
      span = $urandom_range(0, 1) ? 3 : 1023;
      if (pick < 55) begin
        case ($urandom_range(0, 2))
          0: add_item(ACT_SAMPLE, offset_from(rx, thr + 1, thr + 1 + span),
                      offset_from(ry, 0, thr), pick_z(rz));
          1: add_item(ACT_SAMPLE, offset_from(rx, 0, thr),
                      offset_from(ry, thr + 1, thr + 1 + span), pick_z(rz));
          default: add_item(ACT_SAMPLE, offset_from(rx, thr + 1, thr + 1 + span),
                            offset_from(ry, thr + 1, thr + 1 + span), pick_z(rz));
        endcase
      end else if (pick < 80) begin
        add_item(ACT_SAMPLE, offset_from(rx, 0, thr), offset_from(ry, 0, thr), pick_z(rz));
      end else if (pick < 88) begin
        add_random(ACT_SAMPLE);
      end else if (pick < 94) begin
        add_random(ACT_BTN1);
        repeat ($urandom_range(0, 2)) add_random(stray_action(1));
        add_random(ACT_BTN1);
      end else begin
        add_random(ACT_NONE);
      end
    end
    add_random(ACT_BTN2);
    if ($urandom_range(0, 3) == 0) add_random(stray_action(0));
    if ($urandom_range(0, 2) != 0) begin
      add_random(ACT_BTN2);
      if ($urandom_range(0, 2) == 0) add_random(stray_action(1));
    end
    add_random(ACT_BTN1);
  endtask

  // Fill memory to the limit with threshold 0 and references at x = y = 0
  task automatic queue_full_run();
    int unsigned done;
    done = 0;
    add_item(ACT_BTN1, '0, '0, any_reading());
    while (done < MAX_SAMPLES) begin
      if ($urandom_range(0, 49) == 0) add_item(ACT_SAMPLE, '0, '0, any_reading());
      if (done == MAX_SAMPLES / 2) begin
        add_random(ACT_BTN1);
        add_random(ACT_SAMPLE);
        add_random(ACT_BTN1);
      end
      if ($urandom_range(0, 1))
        add_item(ACT_SAMPLE, reading_t'($urandom_range(1, 1023)), any_reading(), any_reading());
      else
        add_item(ACT_SAMPLE, any_reading(), reading_t'($urandom_range(1, 1023)), any_reading());
      done++;
    end
    add_random(ACT_SAMPLE);
    add_random(ACT_BTN2);
    add_random(ACT_NONE);
    add_random(ACT_BTN1);
    add_random(ACT_BTN2);
    add_random(ACT_BTN1);
  endtask

  task automatic drain();
    while (reports_checked != items_queued) @(negedge clk);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    m_thr = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int unsigned quota, logic [THR_W-1:0] thr);
    int unsigned first;
    first = items_queued;
    set_threshold(thr);
    @(posedge clk);
    while (items_queued - first < quota) queue_session(int'(thr));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SAMPLE;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    out_ch.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = THR_RESET;
    m_thr = THR_RESET;
    m_mode = MODE_IDLE;
    m_ref_x = '0;
    m_ref_y = '0;
    m_ref_z = '0;
    m_sum = '0;
    m_count = '0;
    m_avg = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    queue_directed();
    drain();

    random_phase(350, '0);
    park_req <= ~park_req;
    drain();

    tx_idling <= 1'b0;
    rx_idling <= 1'b0;
    random_phase(250, THR_TOP);
    drain();

    tx_idling <= 1'b1;
    rx_idling <= 1'b1;
    random_phase(400, THR_W'($urandom_range(1, 1022)));
    drain();

    rx_idling <= 1'b0;
    random_phase(400, THR_W'($urandom_range(0, 80)));
    drain();

    tx_idling <= 1'b0;
    rx_idling <= 1'b1;
    random_phase(300, THR_RESET);
    park_req <= ~park_req;
    drain();

    set_threshold('0);
    @(posedge clk);
    queue_full_run();
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
